// ===== hw/rtl/tcaq_pkg.sv =====
// tcaq_pkg: shared types and constants for the two-class alternating queue
`timescale 1ns / 1ps
`default_nettype none

package tcaq_pkg;

   // default number of slots in each class queue
   localparam int TCAQ_DEPTH  = 16;
   // width of one data word
   localparam int TCAQ_DATA_W = 32;

   typedef enum logic {
      CMD_ENQUEUE = 1'b0,
      CMD_DEQUEUE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   typedef struct packed {
      cmd_type                         command;
      logic                            queue_class;
      logic signed [TCAQ_DATA_W-1:0]   value;
   } req_type;

   typedef struct packed {
      status_type                      status;
      logic signed [TCAQ_DATA_W-1:0]   out_value;
      logic                            out_class;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tcaq_ram.sv =====
// tcaq_ram: generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module tcaq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/two_class_alternating_queue.sv =====
// two_class_alternating_queue: two linear queues with alternating dequeue service
//
//   channel   direction   handshake             payload
//   req       in          req_valid/req_stall   req_data  (command, queue_class, value)
//   rsp       out         rsp_valid/rsp_stall   rsp_data  (status, out_value, out_class)
//
// An enqueue or a dequeue that finds both queues empty loads the result register
// directly. A dequeue that returns data reads the slot from the class ram, whose
// read data arrive in the cycle after the address. Reset clears pointers, occupancy
// flags, preference and rsp_valid; ram contents and the result payload stay
// undefined. A stalled result holds in the output register and the next request
// is stalled until that register can take a new result.
`timescale 1ns / 1ps
`default_nettype none

module two_class_alternating_queue
   import tcaq_pkg::*;
#(
   parameter int DEPTH = TCAQ_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int                IDX_W = $clog2(DEPTH);
   localparam logic [IDX_W-1:0]  LAST  = IDX_W'(DEPTH - 1);

   // queue control state: per-class pointers and occupancy, shared preference and served class
   logic [IDX_W-1:0] head_ff [2];
   logic [IDX_W-1:0] head_in [2];
   logic [IDX_W-1:0] tail_ff [2];
   logic [IDX_W-1:0] tail_in [2];
   logic             occ_ff  [2];
   logic             occ_in  [2];
   logic             prefer_ff;
   logic             prefer_in;
   logic             served_ff;
   logic             served_in;

   state_type        state_ff;
   state_type        state_in;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_data_ff;
   rsp_type          rsp_data_in;

   // ram ports
   logic                     wr_en     [2];
   logic [IDX_W-1:0]         wr_addr;
   logic                     rd_en     [2];
   logic [IDX_W-1:0]         rd_addr;
   logic [TCAQ_DATA_W-1:0]   rd_data   [2];

   // decode of the current request
   logic             out_free;
   logic             accept;
   logic             is_deq;
   logic             enq_cls;
   logic             enq_full;
   logic             any_occ;
   logic             pick;
   logic             load_status;
   logic             load_read;

   // per-class stores
   for (genvar c = 0; c < 2; c++) begin : g_store
      tcaq_ram #(
         .WIDTH(TCAQ_DATA_W),
         .DEPTH(DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[c]),
         .wr_addr (wr_addr),
         .wr_data (req_data.value),
         .rd_en   (rd_en[c]),
         .rd_addr (rd_addr),
         .rd_data (rd_data[c])
      );
   end

   // request decode
   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      is_deq   = (req_data.command == CMD_DEQUEUE);
      enq_cls  = req_data.queue_class;
      enq_full = occ_ff[enq_cls] && (tail_ff[enq_cls] == LAST);
      any_occ  = occ_ff[0] || occ_ff[1];
      pick     = occ_ff[prefer_ff] ? prefer_ff : !prefer_ff;
      wr_addr  = occ_ff[enq_cls] ? tail_ff[enq_cls] + IDX_W'(1) : '0;
      rd_addr  = head_ff[pick];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_deq && any_occ) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_stall   = 1'b1;
      load_read   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = !out_free;
         end
         ST_READ: begin
            load_read = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
      accept      = req_valid && !req_stall;
      load_status = accept && (!is_deq || !any_occ);
      for (int c = 0; c < 2; c++) begin
         wr_en[c] = accept && !is_deq && !enq_full && (enq_cls == c[0]);
         rd_en[c] = accept && is_deq && any_occ && (pick == c[0]);
      end
   end

   // pointer, occupancy and preference updates
   always_comb begin
      for (int c = 0; c < 2; c++) begin
         head_in[c] = head_ff[c];
         tail_in[c] = tail_ff[c];
         occ_in[c]  = occ_ff[c];
      end
      prefer_in = prefer_ff;
      served_in = served_ff;
      if (accept && !is_deq && !enq_full) begin
         if (occ_ff[enq_cls]) begin
            tail_in[enq_cls] = tail_ff[enq_cls] + IDX_W'(1);
         end else begin
            head_in[enq_cls] = '0;
            tail_in[enq_cls] = '0;
            occ_in[enq_cls]  = 1'b1;
         end
      end
      if (accept && is_deq && any_occ) begin
         if (head_ff[pick] == tail_ff[pick]) begin
            head_in[pick] = '0;
            tail_in[pick] = '0;
            occ_in[pick]  = 1'b0;
         end else begin
            head_in[pick] = head_ff[pick] + IDX_W'(1);
         end
         prefer_in = (pick == 1'b0);
         served_in = pick;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      priority if (load_read) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.status    = STATUS_OK;
         rsp_data_in.out_value = rd_data[served_ff];
         rsp_data_in.out_class = served_ff;
      end else if (load_status) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.out_value = '0;
         rsp_data_in.out_class = 1'b0;
         if (is_deq) begin
            rsp_data_in.status = STATUS_EMPTY;
         end else if (enq_full) begin
            rsp_data_in.status = STATUS_FULL;
         end else begin
            rsp_data_in.status = STATUS_OK;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         prefer_ff    <= 1'b0;
         served_ff    <= 1'b0;
         for (int c = 0; c < 2; c++) begin
            head_ff[c] <= '0;
            tail_ff[c] <= '0;
            occ_ff[c]  <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prefer_ff    <= prefer_in;
         served_ff    <= served_in;
         for (int c = 0; c < 2; c++) begin
            head_ff[c] <= head_in[c];
            tail_ff[c] <= tail_in[c];
            occ_ff[c]  <= occ_in[c];
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== tb/sv/two_class_alternating_queue_tb.sv =====
// two_class_alternating_queue_tb: self-checking testbench for the two-class alternating queue
`timescale 1ns / 1ps

module two_class_alternating_queue_tb;
   import tcaq_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 80;

   // one line of the directed script; count > 1 repeats it with the value stepping up
   typedef struct {
      cmd_type                 cmd;
      logic                    cls;
      logic [TCAQ_DATA_W-1:0]  value;
      int                      count;
      bit                      typed;
      status_type              status;
      logic [TCAQ_DATA_W-1:0]  out_value;
      logic                    out_class;
   } script_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // mirror of the two class queues
   logic [TCAQ_DATA_W-1:0] slot_word [2][TCAQ_DEPTH];
   int  head_idx [2];
   int  tail_idx [2];
   bit  filled [2];
   bit  favor_second;

   rsp_type        pending_rsp_q [$];
   script_row_type script [$];

   int mismatches    = 0;
   int requests_sent = 0;
   int results_seen  = 0;
   int data_results  = 0;
   int full_results  = 0;
   int empty_results = 0;
   int quiet_cycles  = 0;
   int gap_pct       = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   two_class_alternating_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected result of one request; updates the queue mirror
   function automatic rsp_type serve_request(input req_type r);
      rsp_type res;
      int      cls;
      int      pick;
      res = '0;
      if (r.command == CMD_ENQUEUE) begin
         cls = r.queue_class;
         // linear queue: full once the tail reaches the last slot
         if (filled[cls] && tail_idx[cls] >= TCAQ_DEPTH - 1) begin
            res.status = STATUS_FULL;
         end else begin
            if (filled[cls]) begin
               tail_idx[cls]++;
            end else begin
               head_idx[cls] = 0;
               tail_idx[cls] = 0;
               filled[cls]   = 1'b1;
            end
            slot_word[cls][tail_idx[cls]] = r.value;
            res.status = STATUS_OK;
         end
      end else begin
         pick = favor_second ? 1 : 0;
         if (!filled[pick])
            pick = 1 - pick;
         if (!filled[pick]) begin
            res.status = STATUS_EMPTY;
         end else begin
            res.status    = STATUS_OK;
            res.out_value = slot_word[pick][head_idx[pick]];
            res.out_class = pick[0];
            // pointers go back to slot zero only when the queue drains
            if (head_idx[pick] == tail_idx[pick]) begin
               head_idx[pick] = 0;
               tail_idx[pick] = 0;
               filled[pick]   = 1'b0;
            end else begin
               head_idx[pick]++;
            end
            favor_second = (pick == 0);
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
      mismatches++;
   endtask

   task automatic add_row(input cmd_type cmd, input logic cls,
                          input logic [TCAQ_DATA_W-1:0] value, input int count,
                          input bit typed, input status_type status,
                          input logic [TCAQ_DATA_W-1:0] out_value, input logic out_class);
      script_row_type row;
      row.cmd       = cmd;
      row.cls       = cls;
      row.value     = value;
      row.count     = count;
      row.typed     = typed;
      row.status    = status;
      row.out_value = out_value;
      row.out_class = out_class;
      script.push_back(row);
   endtask

   // present one request, hold it until the transfer, then record what it should give
   task automatic offer(input req_type item, input bit typed, input rsp_type typed_rsp);
      rsp_type want;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      want = serve_request(item);
      if (typed)
         want = typed_rsp;
      pending_rsp_q.push_back(want);
      requests_sent++;
   endtask

   // sender pause until every pending result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsp_q.size() != 0);
   endtask

   task automatic set_phase(input int gap, input int stall);
      gap_pct = gap;
      stall_pct <= stall;
   endtask

   // bursts that lean toward enqueues or dequeues, often on one class, to reach full and drain
   task automatic run_random(input int n_items);
      int      done;
      int      burst;
      int      enq_pct;
      bit      pinned;
      logic    pin_cls;
      req_type item;
      done = 0;
      while (done < n_items) begin
         burst   = $urandom_range(40, 12);
         enq_pct = ($urandom_range(1, 0) == 1) ? 80 : 25;
         pinned  = ($urandom_range(1, 0) == 0);
         pin_cls = $urandom_range(1, 0);
         for (int i = 0; i < burst && done < n_items; i++) begin
            item.command     = ($urandom_range(99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
            item.queue_class = pinned ? pin_cls : logic'($urandom_range(1, 0));
            case ($urandom_range(7))
               0: item.value = 32'h7FFF_FFFF;
               1: item.value = 32'h8000_0000;
               default: item.value = $urandom;
            endcase
            offer(item, 1'b0, '0);
            done++;
         end
         if ($urandom_range(9) == 0)
            drain_results();
      end
   endtask

   // receiver stall: random by phase, or a long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_stall   <= 1'b1;
         hold_left   <= HOLD_CYCLES - 1;
         hold_served <= hold_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // result check against the oldest pending expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_rsp_q.size() == 0) begin
            report_mismatch("result with nothing pending", '0, rsp_data.status);
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_data.status != want.status)
               report_mismatch("status", want.status, rsp_data.status);
            if (rsp_data.out_value != want.out_value)
               report_mismatch("out_value", want.out_value, rsp_data.out_value);
            if (rsp_data.out_class != want.out_class)
               report_mismatch("out_class", want.out_class, rsp_data.out_class);
         end
         case (rsp_data.status)
            STATUS_FULL:  full_results++;
            STATUS_EMPTY: empty_results++;
            default:      if (rsp_data.out_value != '0 || rsp_data.out_class) data_results++;
         endcase
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      script_row_type row;
      req_type        item;
      rsp_type        typed_rsp;
      int             phase_gap [4];
      int             phase_stall [4];

      for (int c = 0; c < 2; c++) begin
         head_idx[c] = 0;
         tail_idx[c] = 0;
         filled[c]   = 1'b0;
      end
      favor_second   = 1'b0;
      phase_gap      = '{0, 52, 0, 18};
      phase_stall    = '{0, 0, 52, 18};

      // directed script
      add_row(CMD_DEQUEUE, 1'b0, 32'h0000_0000, 1, 1, STATUS_EMPTY, 32'h0, 1'b0);
      add_row(CMD_DEQUEUE, 1'b1, 32'hFFFF_FFFF, 1, 1, STATUS_EMPTY, 32'h0, 1'b0);
      add_row(CMD_ENQUEUE, 1'b0, 32'h7FFF_FFFF, 1, 1, STATUS_OK, 32'h0, 1'b0);
      add_row(CMD_ENQUEUE, 1'b1, 32'h8000_0000, 1, 1, STATUS_OK, 32'h0, 1'b0);
      add_row(CMD_ENQUEUE, 1'b0, 32'hFFFF_FFFF, 1, 1, STATUS_OK, 32'h0, 1'b0);
      add_row(CMD_ENQUEUE, 1'b1, 32'h0000_0000, 1, 1, STATUS_OK, 32'h0, 1'b0);
      // service alternates, first class preferred out of reset
      add_row(CMD_DEQUEUE, 1'b0, 32'h0, 1, 1, STATUS_OK, 32'h7FFF_FFFF, 1'b0);
      add_row(CMD_DEQUEUE, 1'b0, 32'h0, 1, 1, STATUS_OK, 32'h8000_0000, 1'b1);
      add_row(CMD_DEQUEUE, 1'b1, 32'h0, 1, 1, STATUS_OK, 32'hFFFF_FFFF, 1'b0);
      add_row(CMD_DEQUEUE, 1'b0, 32'h0, 1, 1, STATUS_OK, 32'h0000_0000, 1'b1);
      add_row(CMD_DEQUEUE, 1'b0, 32'h0, 1, 1, STATUS_EMPTY, 32'h0, 1'b0);
      // fill the first class to its last slot, then one more is rejected
      add_row(CMD_ENQUEUE, 1'b0, 32'h0000_1000, TCAQ_DEPTH, 0, STATUS_OK, 32'h0, 1'b0);
      add_row(CMD_ENQUEUE, 1'b0, 32'h5A5A_5A5A, 1, 1, STATUS_FULL, 32'h0, 1'b0);
      // second dequeue falls back to the first class when the second is empty
      add_row(CMD_DEQUEUE, 1'b1, 32'h0, 2, 0, STATUS_OK, 32'h0, 1'b0);
      // linear queue stays full although its front moved
      add_row(CMD_ENQUEUE, 1'b0, 32'hA5A5_A5A5, 1, 1, STATUS_FULL, 32'h0, 1'b0);
      add_row(CMD_ENQUEUE, 1'b1, 32'h1234_5678, 1, 1, STATUS_OK, 32'h0, 1'b0);
      add_row(CMD_DEQUEUE, 1'b0, 32'h0, 3, 0, STATUS_OK, 32'h0, 1'b0);

      // hold reset, then release it
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_phase(0, 0);
      foreach (script[r]) begin
         row = script[r];
         for (int k = 0; k < row.count; k++) begin
            item.command     = row.cmd;
            item.queue_class = row.cls;
            item.value       = row.value + k;
            typed_rsp.status    = row.status;
            typed_rsp.out_value = row.out_value;
            typed_rsp.out_class = row.out_class;
            offer(item, row.typed, typed_rsp);
         end
      end
      drain_results();

      // long receiver hold-off while the sender keeps offering
      hold_requests <= hold_requests + 1;
      run_random(40);
      drain_results();

      // random phases with different idling on each side
      for (int p = 0; p < 4; p++) begin
         set_phase(phase_gap[p], phase_stall[p]);
         run_random(350);
         drain_results();
      end

      set_phase(0, 0);
      repeat (4) @(posedge clock);
      $display("Covered %0d requests and %0d results under four idle and stall mixes",
               requests_sent, results_seen);
      $display("  with a long receiver hold-off: %0d data, %0d full, %0d empty results",
               data_results, full_results, empty_results);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/tcaq_pkg.sv
hw/rtl/tcaq_ram.sv
hw/rtl/two_class_alternating_queue.sv
tb/sv/two_class_alternating_queue_tb.sv
